// ===== hw/rtl/i2cmbe_pkg.sv =====
`timescale 1ns / 1ps
package i2cmbe_pkg;

  // operation codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_WACK  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // register indexes
  localparam logic REG_TICKS = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [7:0] TICKS_RST = 8'd8;
  localparam logic [7:0] LIMIT_RST = 8'd250;

  typedef struct packed {
    logic       cmd_ok;   // command offered and operation known
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic       ack_failed;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  typedef struct packed {
    logic [7:0] ticks_per_unit;
    logic [7:0] ack_poll_limit;
  } cfg_t;

endpackage

// ===== hw/rtl/i2c_master_bit_engine_core.sv =====
`timescale 1ns / 1ps
// A request taken into the input queue is stepped by the sequencer; its result is written
// to the result queue, which drives out_tvalid. Throughput: one request per cycle while that
// queue has room; two-entry queues on both sides absorb stalls.
// Each request is one bus tick; the phase sequencer advances once per request.
// Reset: synchronous, active-low rst_n empties both queues, idles the sequencer,
// drives SCL and SDA high and restores ticks_per_unit to 8 and ack_poll_limit to 250.
module i2c_master_bit_engine_core import i2cmbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_sample, [15:10] zero
  input  logic [15:0] in_tdata,
  // [0] command_valid, [3:1] operation
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_failed, [15:14] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t  cfg_r;
  logic  cfg_wr;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;
  logic  res_valid;
  res_t  res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_LIMIT) ? {24'd0, cfg_r.ack_poll_limit}
                                                  : {24'd0, cfg_r.ticks_per_unit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_unit <= TICKS_RST;
      cfg_r.ack_poll_limit <= LIMIT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TICKS) cfg_r.ticks_per_unit <= cfg_pwdata[7:0];
      else                           cfg_r.ack_poll_limit <= cfg_pwdata[7:0];
    end
  end

  i2cmbe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .command_valid (in_tuser[0]),
    .operation     (in_tuser[3:1]),
    .tx_byte       (in_tdata[7:0]),
    .send_ack      (in_tdata[8]),
    .sda_sample    (in_tdata[9]),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  i2cmbe_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {2'b00, res.ack_failed, res.rx_byte, res.done_res, res.busy_res,
                       res.sda_drive, res.sda_level, res.scl_level};

endmodule

// ===== hw/rtl/i2cmbe_front.sv =====
`timescale 1ns / 1ps
module i2cmbe_front import i2cmbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command_valid,
  input  logic [2:0] operation,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_sample,
  output logic       q_valid,
  input  logic       q_pop,
  output item_t      q_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;
  item_t      item_in;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // classify: unknown operations never start a sequence
  always_comb begin
    item_in.cmd_ok   = command_valid && (operation <= OP_READ);
    item_in.op       = operation;
    item_in.tx_byte  = tx_byte;
    item_in.send_ack = send_ack;
    item_in.sda      = sda_sample;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/i2cmbe_engine.sv =====
`timescale 1ns / 1ps
module i2cmbe_engine import i2cmbe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  output logic  q_pop,
  input  item_t q_item,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_STOP_A   = 4'd3;
  localparam logic [3:0] PH_STOP_B   = 4'd4;
  localparam logic [3:0] PH_WR_D     = 4'd5;
  localparam logic [3:0] PH_WR_H     = 4'd6;
  localparam logic [3:0] PH_WR_L     = 4'd7;
  localparam logic [3:0] PH_ACK_REL  = 4'd8;
  localparam logic [3:0] PH_ACK_CLK  = 4'd9;
  localparam logic [3:0] PH_ACK_POLL = 4'd10;
  localparam logic [3:0] PH_RD_L     = 4'd11;
  localparam logic [3:0] PH_RD_H     = 4'd12;
  localparam logic [3:0] PH_K_A      = 4'd13;
  localparam logic [3:0] PH_K_B      = 4'd14;
  localparam logic [3:0] PH_K_C      = 4'd15;

  logic [3:0] phase_r, phase_nxt;
  logic [9:0] dly_r, dly_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       err_r, err_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       drv_r, drv_nxt;
  logic       ackc_r, ackc_nxt;
  logic       done_nxt;
  logic       fire;

  logic [9:0] unit1, unit2, unit4;

  res_t       oq_r [2];
  logic       oq_wr_r;
  logic       oq_rd_r;
  logic [1:0] oq_cnt_r;
  logic       oq_pop;
  res_t       res_in;

  assign unit1 = {2'b00, cfg.ticks_per_unit};
  assign unit2 = {1'b0, cfg.ticks_per_unit, 1'b0};
  assign unit4 = {cfg.ticks_per_unit, 2'b00};

  assign fire  = q_valid && (oq_cnt_r != 2'd2);
  assign q_pop = fire;

  always_comb begin
    logic       ent_vld;
    logic [3:0] ent_ph;
    logic       poll_do;
    logic [7:0] poll_base;

    phase_nxt = phase_r;
    dly_nxt   = dly_r;
    bit_nxt   = bit_r;
    sh_nxt    = sh_r;
    poll_nxt  = poll_r;
    rx_nxt    = rx_r;
    err_nxt   = err_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    ackc_nxt  = ackc_r;
    done_nxt  = 1'b0;
    ent_vld   = 1'b0;
    ent_ph    = PH_IDLE;
    poll_do   = 1'b0;
    poll_base = poll_r;

    // pick this tick's action
    if (phase_r == PH_IDLE) begin
      if (q_item.cmd_ok) begin
        bit_nxt = 4'd0;
        ent_vld = 1'b1;
        case (q_item.op)
          OP_START: ent_ph = PH_START_A;
          OP_STOP:  ent_ph = PH_STOP_A;
          OP_WRITE: begin
            sh_nxt = q_item.tx_byte;
            ent_ph = PH_WR_D;
          end
          OP_WACK: begin
            err_nxt = 1'b0;
            ent_ph  = PH_ACK_REL;
          end
          default: begin
            sh_nxt   = 8'd0;
            ackc_nxt = q_item.send_ack;
            ent_ph   = PH_RD_L;
          end
        endcase
      end
    end else if (phase_r == PH_ACK_POLL) begin
      poll_do = 1'b1;
    end else if (dly_r > 10'd1) begin
      dly_nxt = dly_r - 10'd1;
    end else begin
      case (phase_r)
        PH_START_A: begin ent_vld = 1'b1; ent_ph = PH_START_B; end
        PH_START_B: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          dly_nxt   = 10'd0;
          done_nxt  = 1'b1;
        end
        PH_STOP_A:  begin ent_vld = 1'b1; ent_ph = PH_STOP_B; end
        PH_STOP_B: begin
          phase_nxt = PH_IDLE;
          dly_nxt   = 10'd0;
          done_nxt  = 1'b1;
        end
        PH_WR_D:    begin ent_vld = 1'b1; ent_ph = PH_WR_H; end
        PH_WR_H:    begin ent_vld = 1'b1; ent_ph = PH_WR_L; end
        PH_WR_L: begin
          bit_nxt = bit_r + 4'd1;
          if (bit_nxt >= 4'd8) begin
            phase_nxt = PH_IDLE;
            dly_nxt   = 10'd0;
            done_nxt  = 1'b1;
          end else begin
            ent_vld = 1'b1;
            ent_ph  = PH_WR_D;
          end
        end
        PH_ACK_REL: begin ent_vld = 1'b1; ent_ph = PH_ACK_CLK; end
        PH_ACK_CLK: begin ent_vld = 1'b1; ent_ph = PH_ACK_POLL; end
        PH_RD_L:    begin ent_vld = 1'b1; ent_ph = PH_RD_H; end
        PH_RD_H: begin
          bit_nxt = bit_r + 4'd1;
          ent_vld = 1'b1;
          if (bit_nxt >= 4'd8) begin
            rx_nxt = sh_r;
            ent_ph = PH_K_A;
          end else begin
            ent_ph = PH_RD_L;
          end
        end
        PH_K_A:     begin ent_vld = 1'b1; ent_ph = PH_K_B; end
        PH_K_B:     begin ent_vld = 1'b1; ent_ph = PH_K_C; end
        PH_K_C: begin
          phase_nxt = PH_IDLE;
          dly_nxt   = 10'd0;
          done_nxt  = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          dly_nxt   = 10'd0;
        end
      endcase
    end

    // apply the pin changes of the phase being entered
    if (ent_vld) begin
      phase_nxt = ent_ph;
      dly_nxt   = 10'd0;
      case (ent_ph)
        PH_START_A: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1; dly_nxt = unit4;
        end
        PH_START_B, PH_STOP_A: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0; drv_nxt = 1'b1; dly_nxt = unit4;
        end
        PH_STOP_B: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1; dly_nxt = unit4;
        end
        PH_WR_D: begin
          scl_nxt = 1'b0;
          sda_nxt = sh_nxt[7];
          drv_nxt = 1'b1;
          sh_nxt  = {sh_nxt[6:0], 1'b0};
          dly_nxt = unit2;
        end
        PH_WR_H:    begin scl_nxt = 1'b1; dly_nxt = unit2; end
        PH_WR_L:    begin scl_nxt = 1'b0; dly_nxt = unit2; end
        PH_ACK_REL: begin sda_nxt = 1'b1; drv_nxt = 1'b0; dly_nxt = unit1; end
        PH_ACK_CLK: begin scl_nxt = 1'b1; dly_nxt = unit1; end
        PH_ACK_POLL: begin
          poll_nxt  = 8'd0;
          poll_base = 8'd0;
          poll_do   = 1'b1;
        end
        PH_RD_L: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; drv_nxt = 1'b0; dly_nxt = unit2;
        end
        PH_RD_H: begin
          scl_nxt = 1'b1;
          sh_nxt  = {sh_nxt[6:0], q_item.sda};
          dly_nxt = unit1;
        end
        PH_K_A: begin
          scl_nxt = 1'b0; sda_nxt = ~ackc_nxt; drv_nxt = 1'b1; dly_nxt = unit2;
        end
        PH_K_B: begin scl_nxt = 1'b1; dly_nxt = unit2; end
        PH_K_C: begin
          scl_nxt = 1'b0;
          dly_nxt = ackc_nxt ? unit2 : 10'd0;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // ack poll: low sample acknowledges, too many high samples run a stop
    if (poll_do) begin
      if (!q_item.sda) begin
        scl_nxt   = 1'b0;
        err_nxt   = 1'b0;
        phase_nxt = PH_IDLE;
        dly_nxt   = 10'd0;
        done_nxt  = 1'b1;
      end else if (poll_base >= cfg.ack_poll_limit) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_STOP_A;
        scl_nxt   = 1'b1;
        sda_nxt   = 1'b0;
        drv_nxt   = 1'b1;
        dly_nxt   = unit4;
      end else begin
        poll_nxt = poll_base + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dly_r   <= 10'd0;
      bit_r   <= 4'd0;
      sh_r    <= 8'd0;
      poll_r  <= 8'd0;
      rx_r    <= 8'd0;
      err_r   <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      ackc_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      dly_r   <= dly_nxt;
      bit_r   <= bit_nxt;
      sh_r    <= sh_nxt;
      poll_r  <= poll_nxt;
      rx_r    <= rx_nxt;
      err_r   <= err_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      ackc_r  <= ackc_nxt;
    end
  end

  always_comb begin
    res_in.scl_level  = scl_nxt;
    res_in.sda_level  = sda_nxt;
    res_in.sda_drive  = drv_nxt;
    res_in.busy_res   = (phase_nxt != PH_IDLE);
    res_in.done_res   = done_nxt;
    res_in.rx_byte    = rx_nxt;
    res_in.ack_failed = err_nxt;
  end

  // result queue: hold the result of every request while the sink stalls
  assign res_valid = (oq_cnt_r != 2'd0);
  assign res       = oq_r[oq_rd_r];
  assign oq_pop    = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (fire) begin
      oq_r[oq_wr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (fire)   oq_wr_r <= ~oq_wr_r;
      if (oq_pop) oq_rd_r <= ~oq_rd_r;
      case ({fire, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + 2'd1;
        2'b01:   oq_cnt_r <= oq_cnt_r - 2'd1;
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

endmodule
